@@ rtl/slrx_pkg.sv @@
// Shared types and constants for the serial line receiver.
package slrx_pkg;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 3;
  localparam int EV_W    = 3;
  localparam int LEN_W   = 6;
  localparam int CNT_W   = 16;
  localparam int LIM_W   = 6;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  // Longest line that can be emitted
  localparam int MAX_LINE = 32;

  // Request types
  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Modes
  localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OVERRUN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HALT    = 3'd4;

  // Events
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_LINE    = 3'd1;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd2;
  localparam logic [EV_W-1:0] EV_OVERRUN = 3'd3;
  localparam logic [EV_W-1:0] EV_HALT    = 3'd4;
  localparam logic [EV_W-1:0] EV_BEAT    = 3'd5;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HALT_DELAY   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LINE_LIMIT   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WAIT_NOTICE  = 2'd3;

  // Configuration reset values
  localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RST = 16'd2000;
  localparam logic [CNT_W-1:0] HALT_DELAY_RST   = 16'd2000;
  localparam logic [LIM_W-1:0] LINE_LIMIT_RST   = 6'd32;
  localparam logic [CNT_W-1:0] WAIT_NOTICE_RST  = 16'd1000;

  // Carriage return
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch an input beat
    logic step;         // apply the buffered item to the mode state
    logic load_single;  // load the one-result beat into the output stage
    logic start_line;   // begin emitting the stored line
    logic emit;         // load the next line character into the output stage
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_line;      // buffered item finishes a non-empty line
    logic emit_last;    // character in the read register is the final one
  } ctrl_status_t;

endpackage

@@ rtl/slrx_req_if.sv @@
// Request channel: valid/ready handshake with request type and byte.
interface slrx_req_if;
  import slrx_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// Result channel: valid/ready handshake with one result beat.
interface slrx_res_if;
  import slrx_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [EV_W-1:0]   event_res;
  logic [BYTE_W-1:0] out_char;
  logic              char_valid;
  logic              last;
  logic [LEN_W-1:0]  line_length;
  logic [CNT_W-1:0]  processed_count;

  modport source (output valid, output mode, output event_res, output out_char,
                  output char_valid, output last, output line_length,
                  output processed_count, input ready);
  modport sink   (input valid, input mode, input event_res, input out_char,
                  input char_valid, input last, input line_length,
                  input processed_count, output ready);
endinterface

@@ rtl/slrx_ctrl.sv @@
// Controller: input buffer flag, output stage flag and line emission sequencer.
module slrx_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   res_valid,
  input  logic                   res_ready,
  input  slrx_pkg::ctrl_status_t status,
  output slrx_pkg::ctrl_cmd_t    cmd
);
  import slrx_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state, state_next;
  logic ibuf_valid, ibuf_valid_next;
  logic out_valid, out_valid_next;
  logic out_free;

  assign req_ready = !ibuf_valid;
  assign res_valid = out_valid;
  assign out_free  = !out_valid || res_ready;

  // Sequence items and line characters
  always_comb begin
    cmd = '0;
    cmd.capture = req_valid && !ibuf_valid;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ibuf_valid && out_free) begin
          cmd.step = 1'b1;
          if (status.is_line) begin
            cmd.start_line = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.load_single = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Track buffer and output stage occupancy
  always_comb begin
    ibuf_valid_next = ibuf_valid;
    if (cmd.capture) begin
      ibuf_valid_next = 1'b1;
    end else if (cmd.step) begin
      ibuf_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (cmd.load_single || cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (res_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ibuf_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ibuf_valid <= ibuf_valid_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

@@ rtl/slrx_datapath.sv @@
// Datapath: configuration, mode state, counters, line store and output stage.
module slrx_datapath #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [slrx_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [slrx_pkg::CFG_W-1:0]       cfg_data,
  input  logic [slrx_pkg::REQ_W-1:0]       req_type,
  input  logic [slrx_pkg::BYTE_W-1:0]      rx_byte,
  input  slrx_pkg::ctrl_cmd_t              cmd,
  output slrx_pkg::ctrl_status_t           status,
  output logic [slrx_pkg::MODE_W-1:0]      mode,
  output logic [slrx_pkg::EV_W-1:0]        event_res,
  output logic [slrx_pkg::BYTE_W-1:0]      out_char,
  output logic                             char_valid,
  output logic                             last,
  output logic [slrx_pkg::LEN_W-1:0]       line_length,
  output logic [slrx_pkg::CNT_W-1:0]       processed_count
);
  import slrx_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 2);
  localparam int CW = (FW > LEN_W) ? FW : LEN_W;
  localparam logic [CW-1:0] NMAX  = CW'((LINE_DEPTH < MAX_LINE) ? LINE_DEPTH : MAX_LINE);
  localparam logic [FW-1:0] DEPTH = FW'(LINE_DEPTH);

  // Configuration registers
  logic [CNT_W-1:0] idle_timeout;
  logic [CNT_W-1:0] halt_delay;
  logic [LIM_W-1:0] line_limit;
  logic [CNT_W-1:0] wait_notice_period;

  // Mode state
  logic [MODE_W-1:0] mode_reg, mode_next;
  logic [FW-1:0]     fill_index, fill_next;
  logic [CNT_W-1:0]  tick_count, tick_next;
  logic [CNT_W-1:0]  stored_total, total_next;

  // Input buffer
  logic [REQ_W-1:0]  ibuf_req;
  logic [BYTE_W-1:0] ibuf_byte;

  // Line store and read side
  logic [BYTE_W-1:0] line_store [LINE_DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     rd_addr;
  logic [LEN_W-1:0]  line_n;

  // Step signals
  logic [EV_W-1:0]   ev;
  logic              wr_en;
  logic              mode_open;
  logic [CW-1:0]     fill_ext;
  logic [CW-1:0]     n_out;
  logic [CW-1:0]     lim_ext;
  logic [CW-1:0]     eff_lim;
  logic [CNT_W-1:0]  thr;
  logic [CNT_W-1:0]  thr1;
  logic [CNT_W-1:0]  tick_inc;
  logic              reached;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout       <= IDLE_TIMEOUT_RST;
      halt_delay         <= HALT_DELAY_RST;
      line_limit         <= LINE_LIMIT_RST;
      wait_notice_period <= WAIT_NOTICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT: idle_timeout       <= cfg_data;
        REG_HALT_DELAY:   halt_delay         <= cfg_data;
        REG_LINE_LIMIT:   line_limit         <= cfg_data[LIM_W-1:0];
        REG_WAIT_NOTICE:  wait_notice_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch an input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ibuf_req  <= req_type;
      ibuf_byte <= rx_byte;
    end
  end

  // Line length and effective limit
  assign fill_ext  = CW'(fill_index);
  assign n_out     = (fill_ext > NMAX) ? NMAX : fill_ext;
  assign lim_ext   = CW'(line_limit);
  assign eff_lim   = (lim_ext > NMAX) ? NMAX : lim_ext;
  assign mode_open = (mode_reg == MODE_WAIT) || (mode_reg == MODE_LOAD);

  // Tick threshold for the current mode
  always_comb begin
    case (mode_reg)
      MODE_WAIT: thr = wait_notice_period;
      MODE_LOAD: thr = idle_timeout;
      default:   thr = halt_delay;
    endcase
  end
  assign thr1     = (thr == '0) ? CNT_W'(1) : thr;
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + CNT_W'(1);
  assign reached  = tick_inc >= thr1;

  // Work out the effect of the buffered item
  always_comb begin
    mode_next  = mode_reg;
    fill_next  = fill_index;
    tick_next  = tick_count;
    total_next = stored_total;
    ev         = EV_NONE;
    wr_en      = 1'b0;
    case (ibuf_req)
      REQ_BYTE: begin
        if (mode_open) begin
          mode_next = MODE_LOAD;
          tick_next = '0;
          if (ibuf_byte == CHAR_CR) begin
            fill_next = '0;
            ev        = EV_LINE;
          end else begin
            wr_en      = fill_index < DEPTH;
            fill_next  = (fill_index <= DEPTH) ? fill_index + FW'(1) : fill_index;
            total_next = stored_total + CNT_W'(1);
            if (CW'(fill_next) > eff_lim) begin
              mode_next = MODE_OVERRUN;
              ev        = EV_OVERRUN;
            end
          end
        end
      end
      REQ_TICK: begin
        case (mode_reg)
          MODE_WAIT: begin
            tick_next = reached ? '0 : tick_inc;
            if (reached) ev = EV_BEAT;
          end
          MODE_LOAD: begin
            tick_next = reached ? '0 : tick_inc;
            if (reached) begin
              mode_next = MODE_TIMEOUT;
              ev        = EV_TIMEOUT;
            end
          end
          MODE_TIMEOUT, MODE_OVERRUN: begin
            tick_next = reached ? '0 : tick_inc;
            if (reached) begin
              mode_next  = MODE_HALT;
              fill_next  = '0;
              total_next = '0;
              ev         = EV_HALT;
            end
          end
          default: ;
        endcase
      end
      REQ_CLEAR: begin
        if (mode_reg == MODE_HALT) begin
          mode_next = MODE_WAIT;
          tick_next = '0;
        end
      end
      default: ;
    endcase
  end

  assign status.is_line = (ibuf_req == REQ_BYTE) && mode_open &&
                          (ibuf_byte == CHAR_CR) && (n_out != '0);
  assign status.emit_last = (rd_idx + CW'(1)) == CW'(line_n);

  // Update mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_WAIT;
      fill_index   <= '0;
      tick_count   <= '0;
      stored_total <= '0;
    end else if (cmd.step) begin
      mode_reg     <= mode_next;
      fill_index   <= fill_next;
      tick_count   <= tick_next;
      stored_total <= total_next;
    end
  end

  // Read address: start of line, next character, or hold
  always_comb begin
    if (cmd.start_line) begin
      rd_addr = '0;
    end else if (cmd.emit) begin
      rd_addr = AW'(rd_idx + CW'(1));
    end else begin
      rd_addr = AW'(rd_idx);
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.step && wr_en) begin
      line_store[AW'(fill_index)] <= ibuf_byte;
    end
    rdata <= line_store[rd_addr];
  end

  // Advance the emission index
  always_ff @(posedge clk) begin
    if (cmd.start_line) begin
      rd_idx <= '0;
      line_n <= LEN_W'(n_out);
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + CW'(1);
    end
  end

  // Load the output stage
  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      mode            <= mode_next;
      event_res       <= ev;
      out_char        <= '0;
      char_valid      <= 1'b0;
      last            <= 1'b1;
      line_length     <= '0;
      processed_count <= total_next;
    end else if (cmd.emit) begin
      mode            <= mode_reg;
      event_res       <= EV_LINE;
      out_char        <= rdata;
      char_valid      <= 1'b1;
      last            <= status.emit_last;
      line_length     <= line_n;
      processed_count <= stored_total;
    end
  end

endmodule

@@ rtl/serial_line_receiver_with_timeouts_top.sv @@
// Serial line receiver with idle and halt timeouts: top level.
// An accepted item is held in the input buffer, then stepped into the output stage.
// The one-entry input buffer takes a new item only once the last one has been stepped.
// A finished line is emitted from the line store as one beat per character, in order.
// Synchronous reset clears mode, counters and configuration to defaults.
// The line store is not cleared at reset and needs no clearing pass.
module serial_line_receiver_with_timeouts_top #(
  parameter int LINE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slrx_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [slrx_pkg::CFG_W-1:0]    cfg_data,
  slrx_req_if.sink                      req,
  slrx_res_if.source                    res
);
  import slrx_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  slrx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  slrx_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req.req_type),
    .rx_byte         (req.rx_byte),
    .cmd             (cmd),
    .status          (status),
    .mode            (res.mode),
    .event_res       (res.event_res),
    .out_char        (res.out_char),
    .char_valid      (res.char_valid),
    .last            (res.last),
    .line_length     (res.line_length),
    .processed_count (res.processed_count)
  );

  // A character beat always belongs to a non-empty finished line
  a_char_is_line: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.char_valid |-> res.event_res == EV_LINE && res.line_length != '0)
    else $error("character beat without line-done event");

  // No new item is processed while a line is being emitted
  a_no_step_in_line: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !cmd.step)
    else $error("item processed during line emission");

  // Emitting the final character presents a beat marked last
  a_last_char: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.emit_last |=> res.valid && res.last && res.char_valid)
    else $error("final line character not marked last");

endmodule
